// ===== rtl/ptd_pkg.sv =====
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types and constants for the periodic task dispatcher.
// ----------------------------------------------------------------------------
package ptd_pkg;

    localparam int SLOTS     = 7;
    localparam int TASKS     = 7;
    localparam int IDX_W     = 3;
    localparam int PERIOD_W  = 16;
    localparam int TIME_W    = 32;

    localparam logic CMD_POLL    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    localparam logic [SLOTS-1:0][PERIOD_W-1:0] PERIOD_RESET = '{
        16'd260, 16'd500, 16'd100, 16'd6000, 16'd450, 16'd300, 16'd50
    };

    typedef struct packed {
        logic              command;
        logic [TIME_W-1:0] current_time;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0] task_index;
        logic             overrun;
        logic             last_of_run;
    } t_out;

    typedef struct packed {
        logic [TIME_W-1:0]   start;
        logic [PERIOD_W-1:0] period;
        logic [TIME_W-1:0]   now;
    } t_alu_req;

    typedef struct packed {
        logic              fire;
        logic              overrun;
        logic [TIME_W-1:0] next_start;
    } t_alu_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

endpackage

// ===== rtl/periodic_task_dispatcher_unit.sv =====
// ----------------------------------------------------------------------------
// periodic_task_dispatcher_unit
// A restart transaction aligns all start times. A poll walks the seven tasks
// through the shared evaluation unit; one fired task per cycle then leaves the
// output register unless the output stalls; input stalls until the poll ends.
// Synchronous active-low reset clears start times and restores the periods.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher_unit import ptd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in                 i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out                o_out,
    input  logic                i_cfg_we,
    input  logic [IDX_W-1:0]    i_cfg_index,
    input  logic [PERIOD_W-1:0] i_cfg_data
);

    logic [SLOTS-1:0][PERIOD_W-1:0] r_period;
    t_alu_req                       alu_req;
    t_alu_res                       alu_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_we && (i_cfg_index < IDX_W'(SLOTS))) begin
            r_period[i_cfg_index] <= i_cfg_data;
        end
    end

    ptd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_period    (r_period),
        .o_alu_req   (alu_req),
        .i_alu_res   (alu_res)
    );

    ptd_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

endmodule

// ===== rtl/ptd_alu.sv =====
// ----------------------------------------------------------------------------
// ptd_alu
// Shared task evaluation unit: elapsed time, due and overrun tests, next start.
// ----------------------------------------------------------------------------
module ptd_alu import ptd_pkg::*; (
    input  t_alu_req i_req,
    output t_alu_res o_res
);

    logic [TIME_W-1:0]   elapsed;
    logic [PERIOD_W:0]   twice;

    always_comb begin
        elapsed          = i_req.now - i_req.start;
        twice            = {i_req.period, 1'b0};
        o_res.fire       = elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, i_req.period};
        o_res.overrun    = elapsed > {{(TIME_W-PERIOD_W-1){1'b0}}, twice};
        o_res.next_start = o_res.overrun ? i_req.now
                         : i_req.start + {{(TIME_W-PERIOD_W){1'b0}}, i_req.period};
    end

endmodule

// ===== rtl/ptd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptd_ctrl
// Sequencer: walks the tasks through the shared unit, keeps the start times,
// and delivers one result transaction per fired task.
// ----------------------------------------------------------------------------
module ptd_ctrl import ptd_pkg::*; (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  t_in                              i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output t_out                             o_out,
    input  logic [SLOTS-1:0][PERIOD_W-1:0]   i_period,
    output t_alu_req                         o_alu_req,
    input  t_alu_res                         i_alu_res
);

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_k, n_k;
    logic [TIME_W-1:0] r_now, n_now;
    logic [SLOTS-1:0]  r_fire, n_fire;
    logic [SLOTS-1:0]  r_ovr, n_ovr;
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;
    logic [TIME_W-1:0] r_start [SLOTS];

    logic              accept;
    logic              restart;
    logic              wr_one;
    logic              load;
    logic [IDX_W-1:0]  sel;
    logic [SLOTS-1:0]  rest;

    assign accept      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign o_alu_req.start  = r_start[r_k];
    assign o_alu_req.period = i_period[r_k];
    assign o_alu_req.now    = r_now;

    always_comb begin
        sel = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_fire[i]) begin
                sel = IDX_W'(i);
            end
        end
        rest = r_fire & ~(SLOTS'(1) << sel);
    end

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_now       = r_now;
        n_fire      = r_fire;
        n_ovr       = r_ovr;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        restart     = 1'b0;
        wr_one      = 1'b0;
        load        = 1'b0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in.command == CMD_RESTART) begin
                        restart = 1'b1;
                    end else begin
                        n_now   = i_in.current_time;
                        n_k     = '0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                wr_one      = i_alu_res.fire;
                n_fire[r_k] = i_alu_res.fire;
                n_ovr[r_k]  = i_alu_res.overrun;
                if (r_k == IDX_W'(TASKS - 1)) begin
                    n_state = (n_fire != '0) ? ST_EMIT : ST_IDLE;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    load              = 1'b1;
                    n_fire            = rest;
                    n_out.task_index  = sel;
                    n_out.overrun     = r_ovr[sel];
                    n_out.last_of_run = (rest == '0);
                    n_out_valid       = 1'b1;
                    if (rest == '0) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_fire      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_fire      <= n_fire;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now <= n_now;
        r_ovr <= n_ovr;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_start[i] <= '0;
            end
        end else if (restart) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_start[i] <= i_in.current_time;
            end
        end else if (wr_one) begin
            r_start[r_k] <= i_alu_res.next_start;
        end
    end

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_fire == '0))
        else $error("fired tasks pending while idle");

    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_k <= IDX_W'(TASKS - 1)))
        else $error("task index beyond task count during scan");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && rest == '0) |=> (r_fire == '0 && r_out.last_of_run))
        else $error("final transaction left fired tasks behind");

    a_restart_aligns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        restart |=> (r_start[0] == $past(i_in.current_time)))
        else $error("restart did not align start times");

endmodule

// ===== sim/periodic_task_dispatcher_unit_tb.sv =====
// ----------------------------------------------------------------------------
// periodic_task_dispatcher_unit_tb
// Self-checking testbench for the periodic task dispatcher. Restart and poll
// transactions are sent with random gaps while the result side stalls at
// random. A scoreboard keeps its own period table and start times, predicts
// the fired tasks of each poll, and compares every result in order.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher_unit_tb import ptd_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [PERIOD_W-1:0] t_period_set [SLOTS];

    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam logic [IDX_W-1:0] SPARE_INDEX = IDX_W'(SLOTS);
    localparam t_period_set BOOT_PERIODS = '{
        16'd50, 16'd300, 16'd450, 16'd6000, 16'd100, 16'd500, 16'd260
    };

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    t_in                 i_in        = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out                o_out;
    logic                i_cfg_we    = 1'b0;
    logic [IDX_W-1:0]    i_cfg_index = '0;
    logic [PERIOD_W-1:0] i_cfg_data  = '0;

    t_period_set         period_tbl = BOOT_PERIODS;
    logic [TIME_W-1:0]   start_tbl [SLOTS] = '{default: '0};
    t_out                due_tasks_q [$];

    int gap_pct    = 30;
    int stall_pct  = 30;
    int stall_run  = 0;
    int idle_count = 0;
    int errors     = 0;
    int n_sent     = 0;
    int n_fired    = 0;
    int n_overrun  = 0;
    int n_settings = 0;

    periodic_task_dispatcher_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS) $display("%0t: %s", $time, msg);
    endfunction

    function automatic void predict_firings(input t_in item);
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] per;
        t_out              fired [$];
        t_out              res;
        if (item.command == CMD_RESTART) begin
            for (int k = 0; k < SLOTS; k++) start_tbl[k] = item.current_time;
            return;
        end
        for (int k = 0; k < TASKS; k++) begin
            per     = TIME_W'(period_tbl[k]);
            elapsed = item.current_time - start_tbl[k];
            if (elapsed >= per) begin
                res.task_index  = IDX_W'(k);
                res.last_of_run = 1'b0;
                if (elapsed > (per << 1)) begin
                    start_tbl[k] = item.current_time;
                    res.overrun  = 1'b1;
                end else begin
                    start_tbl[k] = start_tbl[k] + per;
                    res.overrun  = 1'b0;
                end
                fired.push_back(res);
            end
        end
        if (fired.size() != 0) fired[fired.size()-1].last_of_run = 1'b1;
        foreach (fired[i]) due_tasks_q.push_back(fired[i]);
    endfunction

    task automatic send_item(input logic cmd, input logic [TIME_W-1:0] now);
        t_in item;
        item.command      = cmd;
        item.current_time = now;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
        predict_firings(item);
    endtask

    // Waits until every predicted result has arrived, then lets the block drain.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (due_tasks_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_periods(input t_period_set vals, input bit poke_spare);
        if (poke_spare) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= SPARE_INDEX;
            i_cfg_data  <= '1;
            @(posedge i_clk);
        end
        for (int k = 0; k < SLOTS; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= IDX_W'(k);
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            period_tbl[k] = vals[k];
        end
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic test_default_periods();
        send_item(CMD_POLL, 32'd0);
        send_item(CMD_POLL, 32'd49);
        send_item(CMD_POLL, 32'd50);
        send_item(CMD_POLL, 32'd300);
        send_item(CMD_POLL, 32'd6000);
    endtask

    task automatic test_period_limits();
        settle();
        load_periods('{16'd0, 16'd65535, 16'd0, 16'd65535, 16'd1, 16'd2, 16'd65535}, 1'b0);
        send_item(CMD_RESTART, 32'd1000);
        send_item(CMD_POLL, 32'd1000);
        send_item(CMD_POLL, 32'd1001);
        send_item(CMD_POLL, 32'd1000 + 32'd131070);
        send_item(CMD_RESTART, 32'd5000);
        send_item(CMD_POLL, 32'd5000 + 32'd131071);
    endtask

    task automatic test_time_wrap();
        send_item(CMD_RESTART, 32'hFFFF_FFF0);
        send_item(CMD_POLL, 32'h0000_0010);
        send_item(CMD_RESTART, 32'h8000_0000);
        send_item(CMD_POLL, 32'h7FFF_FFFF);
        send_item(CMD_RESTART, 32'hFFFF_FFFF);
        send_item(CMD_POLL, 32'hFFFF_FFFF);
        send_item(CMD_POLL, 32'h0000_0000);
    endtask

    task automatic test_spare_index();
        settle();
        load_periods('{16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7}, 1'b1);
        send_item(CMD_RESTART, 32'd0);
        send_item(CMD_POLL, 32'd10);
        send_item(CMD_POLL, 32'd20);
    endtask

    task automatic test_random_phases();
        t_period_set       pset;
        logic [TIME_W-1:0] now_t;
        int                mode;
        int                span;
        int                pick;
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            mode = ph % 3;
            for (int k = 0; k < SLOTS; k++) begin
                case (mode)
                    0: pset[k] = PERIOD_W'($urandom_range(1, 40));
                    1: begin
                        case ($urandom_range(0, 3))
                            0: pset[k] = '0;
                            1: pset[k] = '1;
                            2: pset[k] = PERIOD_W'($urandom_range(1, 40));
                            default: pset[k] = PERIOD_W'($urandom);
                        endcase
                    end
                    default: pset[k] = PERIOD_W'($urandom_range(0, 8));
                endcase
            end
            load_periods(pset, ph == 5);
            gap_pct   = (ph == 2) ? 0 : $urandom_range(10, 40);
            stall_pct = (ph == 3) ? 0 : $urandom_range(10, 40);
            now_t = (ph == 4) ? 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 300)) : $urandom;
            send_item(CMD_RESTART, now_t);
            for (int i = 0; i < 36; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    send_item(CMD_RESTART, now_t);
                end else if (pick < 7) begin
                    send_item(CMD_RESTART, $urandom);
                end else if (pick < 12) begin
                    send_item(CMD_POLL, $urandom);
                end else if (pick < 14) begin
                    settle();
                end else begin
                    span = (mode == 2) ? 20 : 100;
                    if (mode == 1 && $urandom_range(0, 9) == 0) span = 140000;
                    now_t = now_t + TIME_W'($urandom_range(0, span));
                    send_item(CMD_POLL, now_t);
                end
            end
        end
    endtask

    task automatic test_steady_stream();
        logic [TIME_W-1:0] now_t;
        gap_pct   = 0;
        stall_pct = 0;
        now_t     = $urandom;
        send_item(CMD_RESTART, now_t);
        for (int i = 0; i < 20; i++) begin
            now_t = now_t + TIME_W'($urandom_range(0, 60));
            send_item(CMD_POLL, now_t);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || stall_pct == 0) begin
            i_out_stall <= 1'b0;
            stall_run   <= 0;
        end else if (stall_run != 0) begin
            i_out_stall <= 1'b1;
            stall_run   <= stall_run - 1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            i_out_stall <= 1'b1;
            stall_run   <= $urandom_range(0, 9);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_out exp;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_tasks_q.size() == 0) begin
                note_error($sformatf("unexpected result: task %0d overrun %0b last %0b",
                    o_out.task_index, o_out.overrun, o_out.last_of_run));
            end else begin
                exp = due_tasks_q.pop_front();
                n_fired++;
                if (exp.overrun) n_overrun++;
                if (o_out.task_index !== exp.task_index || o_out.overrun !== exp.overrun
                        || o_out.last_of_run !== exp.last_of_run) begin
                    note_error($sformatf(
                        "mismatch: expected task %0d overrun %0b last %0b, got %0d %0b %0b",
                        exp.task_index, exp.overrun, exp.last_of_run,
                        o_out.task_index, o_out.overrun, o_out.last_of_run));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
        end
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", idle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_periods();
        test_period_limits();
        test_time_wrap();
        test_spare_index();
        test_random_phases();
        test_steady_stream();
        settle();
        if (due_tasks_q.size() != 0) begin
            note_error($sformatf("%0d expected results never arrived", due_tasks_q.size()));
        end
        $display("Run covered %0d input transactions under %0d period settings,",
            n_sent, n_settings);
        $display("with %0d dispatched tasks checked, %0d of them overruns; %0d errors.",
            n_fired, n_overrun, errors);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
